// ===== hdl/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg: shared types, constants and functions for the code expander
// Code ROM, syllable record, and the letter spelling functions.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int QDepth = 4;
	localparam int QIdxW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [7:0] RomHighBase  = 8'h7b;
	localparam logic [7:0] RomLowTop    = 8'h3a;
	localparam logic [7:0] RomLowOffset = 8'd133;

	localparam int MaxLetters = 6;
	localparam int LetterIdxW = $clog2(MaxLetters);
	localparam int LetterCntW = $clog2(MaxLetters + 1);

	typedef enum logic [1:0] {
		MODE_CODE    = 2'd0,
		MODE_FULL    = 2'd1,
		MODE_INITIAL = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] s;
		logic [7:0] y;
	} syl_t;

	typedef struct packed {
		logic [31:0] w;
		logic [2:0]  n;
	} fin_t;

	typedef struct packed {
		logic [MaxLetters-1:0][7:0] ch;
		logic [LetterCntW-1:0]      n;
	} exp_t;

	localparam logic [0:383][7:0] CodeRom = {
		"deuiyivibuybrfwz", "jigolivsvezlyujw", "faqigsdkxyxmjmye", "yrdaxdgeugleuhzi",
		"hejqkeiuykjyigxc", "xthvdufhtijnernm", "hlwugrdivgdvqrjc", "xnmzgkbkxxzotsyy",
		"ubngvuruwfsidofu", "jubillufynihxijx", "yjuuvhdjmfqudmho", "yhlddyanqyysqmue",
		"xuhfmmhbbcmyffwh", "hwfzdhpicirjnjhk", "tabfglijsojdhucl", "lvytuopymudlgvfj",
		"wobzxwwjds",
		"vjbmuvfgtmgugjlm", "navfnibytbtlbjkl", "zvlqujbltyhrggba", "iimjlyludbsuvrsj",
		"vkjprimotugdir",
		"qdwlhjlkpnzkdgkjmemnzupmsvdrqqjttcplbois"
	};

	function automatic logic is_rom_byte(input logic [7:0] b);
		return (b >= RomHighBase) || (b <= RomLowTop);
	endfunction

	// returns {first letter, second letter}
	function automatic logic [15:0] rom_code(input logic [7:0] b);
		logic [7:0] idx;
		logic [8:0] pos;
		if (b >= RomHighBase) begin
			idx = b - RomHighBase;
		end else begin
			idx = b + RomLowOffset;
		end
		pos = {idx, 1'b0};
		return {CodeRom[pos], CodeRom[pos + 9'd1]};
	endfunction

	function automatic logic in_set(input logic [7:0] c, input logic [63:0] set);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (set[8*k +: 8] != 8'h00 && set[8*k +: 8] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// left-align an n-letter string in a 32-bit word
	function automatic fin_t put(input logic [31:0] v, input logic [2:0] n);
		fin_t f;
		f.n = n;
		f.w = v << (8 * (4 - n));
		return f;
	endfunction

	function automatic fin_t spell_final(input logic [7:0] s, input logic [7:0] y);
		fin_t f;
		f.w = '0;
		f.n = '0;
		case (y)
			"a": if (s != "a") f = put("a", 3'd1);
			"b": f = put("ou", 3'd2);
			"c": f = put("iao", 3'd3);
			"d": f = in_set(s, "jlnqx") ? put("iang", 3'd4) : put("uang", 3'd4);
			"e": if (s != "e") f = put("e", 3'd1);
			"f": f = put("en", 3'd2);
			"g": f = (s != "e") ? put("eng", 3'd3) : put("ng", 3'd2);
			"h": f = (s != "a") ? put("ang", 3'd3) : put("ng", 3'd2);
			"j": f = put("an", 3'd2);
			"k": f = put("ao", 3'd2);
			"l": f = put("ai", 3'd2);
			"m": f = put("ian", 3'd3);
			"n": f = (s != "a" && s != "e") ? put("in", 3'd2) : put("n", 3'd1);
			"o": if (s != "o") begin
				f = in_set(s, "abfmpqw") ? put("o", 3'd1) : put("uo", 3'd2);
			end
			"p": f = put("un", 3'd2);
			"q": f = put("iu", 3'd2);
			"r": f = (s == "e") ? put("r", 3'd1) : put("uan", 3'd3);
			"s": f = in_set(s, "jqx") ? put("iong", 3'd4) : put("ong", 3'd3);
			"t": f = put("ue", 3'd2);
			"v": f = in_set(s, "ln") ? put("v", 3'd1) : put("ui", 3'd2);
			"w": f = in_set(s, "djlqx") ? put("ia", 3'd2) : put("ua", 3'd2);
			"x": f = put("ie", 3'd2);
			"y": f = in_set(s, "ighkuv") ? put("uai", 3'd3) : put("ing", 3'd3);
			"z": f = put("ei", 3'd2);
			default: f = put({24'h0, y}, 3'd1);
		endcase
		return f;
	endfunction

	function automatic exp_t expand(input syl_t syl);
		exp_t e;
		fin_t f;
		logic [1:0][7:0] ic;
		logic [1:0] ni;
		int j;
		e.ch = '0;
		e.n = '0;
		ic = '0;
		ni = 2'd1;
		case (mode_t'(syl.mode))
			MODE_FULL: begin
				ic[0] = syl.s;
				if (syl.s == "i") begin
					ic[0] = "c";
					ic[1] = "h";
					ni = 2'd2;
				end else if (syl.s == "u") begin
					ic[0] = "s";
					ic[1] = "h";
					ni = 2'd2;
				end else if (syl.s == "v") begin
					ic[0] = "z";
					ic[1] = "h";
					ni = 2'd2;
				end
				f = spell_final(syl.s, syl.y);
				for (int k = 0; k < MaxLetters; k++) begin
					j = k - int'(ni);
					if (k < int'(ni)) begin
						e.ch[k] = ic[k[0]];
					end else if (j < 4) begin
						e.ch[k] = f.w[31 - 8*j -: 8];
					end
				end
				e.n = LetterCntW'(ni) + LetterCntW'(f.n);
			end
			MODE_INITIAL: begin
				e.ch[0] = (syl.s == "i") ? 8'("c") :
					(syl.s == "u") ? 8'("s") :
					(syl.s == "v") ? 8'("z") : syl.s;
				e.n = LetterCntW'(1);
			end
			default: begin
				e.ch[0] = syl.s;
				e.ch[1] = syl.y;
				e.n = LetterCntW'(2);
			end
		endcase
		return e;
	endfunction

endpackage

// ===== hdl/pce_byte_if.sv =====
// ----------------------------------------------------------------------------
// pce_byte_if: compressed byte channel
// Valid/ready channel carrying one byte of the syllable stream.
// ----------------------------------------------------------------------------
interface pce_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/pce_char_if.sv =====
// ----------------------------------------------------------------------------
// pce_char_if: expanded letter channel
// Valid/ready channel carrying one letter and its end-of-syllable mark.
// ----------------------------------------------------------------------------
interface pce_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       syllable_end;

	modport source (output valid, output out_char, output syllable_end, input ready);
	modport sink (input valid, input out_char, input syllable_end, output ready);
endinterface

// ===== hdl/pinyin_code_expander_core.sv =====
// ----------------------------------------------------------------------------
// pinyin_code_expander_core: compressed syllable to letter expander
// Front intake, syllable queue and letter generator.
// ----------------------------------------------------------------------------
// Each accepted byte is a code byte (expanded at once through the code ROM)
// or one half of a raw letter pair (the first half yields nothing). A
// syllable gives one to six letters, sent one per cycle on the letter
// channel while it is ready; the last letter carries syllable_end. The
// letter output is the limit: the next syllable follows with no gap.
// Bytes are taken one per cycle while the four-entry syllable queue has
// room, so input stalls only when letter output falls behind by more than
// four syllables. The mode register is to be written through
// cfg_we/cfg_wdata only while the block is idle; the block does not check.
module pinyin_code_expander_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	pce_byte_if.sink   syl,
	pce_char_if.source letter
);
	import pce_pkg::*;

	logic push_valid;
	logic push_ready;
	syl_t push_data;
	logic pop_valid;
	logic pop_ready;
	syl_t pop_data;

	pce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.syl        (syl),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.letter    (letter)
	);
endmodule

// ===== hdl/pce_front.sv =====
// ----------------------------------------------------------------------------
// pce_front: byte intake and classification
// Holds the mode register and a pending raw letter, and pushes one syllable
// record per complete code byte or raw letter pair.
// ----------------------------------------------------------------------------
module pce_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata,
	pce_byte_if.sink      syl,
	output logic          push_valid,
	input  logic          push_ready,
	output pce_pkg::syl_t push_data
);
	import pce_pkg::*;

	logic [1:0] mode_reg_q;
	logic       pending_q;
	logic [7:0] held_q;
	logic       xfer;
	logic       rom_hit;
	logic [15:0] code;

	assign syl.ready = push_ready;
	assign xfer      = syl.valid && syl.ready;
	assign rom_hit   = is_rom_byte(syl.in_byte);
	assign code      = rom_code(syl.in_byte);

	always_comb begin
		push_data.mode = mode_reg_q;
		if (pending_q) begin
			push_data.s = held_q;
			push_data.y = syl.in_byte;
		end else begin
			push_data.s = code[15:8];
			push_data.y = code[7:0];
		end
	end

	assign push_valid = syl.valid && (pending_q || rom_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg_q <= MODE_CODE;
			pending_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_reg_q <= cfg_wdata;
			end
			if (xfer) begin
				if (pending_q) begin
					pending_q <= 1'b0;
				end else if (!rom_hit) begin
					pending_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && !pending_q && !rom_hit) begin
			held_q <= syl.in_byte;
		end
	end

	a_raw_first_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !pending_q && !rom_hit |=> pending_q)
		else $error("raw first letter did not set pending");
	a_pending_clears: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && pending_q |=> !pending_q)
		else $error("pair completion did not clear pending");
	a_pending_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (pending_q || rom_hit) |-> push_valid && push_ready)
		else $error("complete syllable not pushed");
endmodule

// ===== hdl/pce_queue.sv =====
// ----------------------------------------------------------------------------
// pce_queue: syllable record queue
// Small register FIFO that decouples byte intake from letter output.
// ----------------------------------------------------------------------------
module pce_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pce_pkg::syl_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pce_pkg::syl_t pop_data
);
	import pce_pkg::*;

	syl_t             entries_q [QDepth];
	logic [QIdxW-1:0] wr_q;
	logic [QIdxW-1:0] rd_q;
	logic [QCntW-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != QCntW'(QDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QIdxW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QIdxW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("queue count beyond depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + QCntW'(1))
		else $error("queue count did not advance on push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QIdxW'(wr_q - rd_q) == QIdxW'(count_q))
		else $error("queue pointers and count disagree");
endmodule

// ===== hdl/pce_back.sv =====
// ----------------------------------------------------------------------------
// pce_back: letter generator
// Spells the syllable at the queue head into a letter buffer and sends one
// letter per transfer, marking the last letter of each syllable.
// ----------------------------------------------------------------------------
module pce_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  pce_pkg::syl_t pop_data,
	pce_char_if.source    letter
);
	import pce_pkg::*;

	logic [MaxLetters-1:0][7:0] buf_q;
	logic [LetterCntW-1:0]      len_q;
	logic [LetterCntW-1:0]      pos_q;
	logic                       busy_q;
	logic                       last;
	logic                       xfer;
	exp_t                       spelled;

	assign last    = (pos_q == len_q - LetterCntW'(1));
	assign xfer    = letter.valid && letter.ready;
	assign spelled = expand(pop_data);

	assign pop_ready           = !busy_q || (xfer && last);
	assign letter.valid        = busy_q;
	assign letter.out_char     = buf_q[pos_q[LetterIdxW-1:0]];
	assign letter.syllable_end = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (xfer) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q + LetterCntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			buf_q <= spelled.ch;
			len_q <= spelled.n;
		end
	end

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (len_q != '0) && (pos_q < len_q))
		else $error("letter position outside syllable");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !last |=> busy_q && pos_q == $past(pos_q) + LetterCntW'(1))
		else $error("letter position did not advance");
	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && pop_valid |=> busy_q && pos_q == '0)
		else $error("waiting syllable not loaded");
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for pinyin_code_expander_core
// Sends compressed syllable bytes with random gaps, predicts every letter from
// a local copy of the code table and spelling rules, and checks each letter
// transfer against the oldest prediction while the letter side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
	import pce_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} letter_t;

	localparam logic [0:383][7:0] SylCodes = {
		"deuiyivibuybrfwz", "jigolivsvezlyujw", "faqigsdkxyxmjmye", "yrdaxdgeugleuhzi",
		"hejqkeiuykjyigxc", "xthvdufhtijnernm", "hlwugrdivgdvqrjc", "xnmzgkbkxxzotsyy",
		"ubngvuruwfsidofu", "jubillufynihxijx", "yjuuvhdjmfqudmho", "yhlddyanqyysqmue",
		"xuhfmmhbbcmyffwh", "hwfzdhpicirjnjhk", "tabfglijsojdhucl", "lvytuopymudlgvfj",
		"wobzxwwjds",
		"vjbmuvfgtmgugjlm", "navfnibytbtlbjkl", "zvlqujbltyhrggba", "iimjlyludbsuvrsj",
		"vkjprimotugdir",
		"qdwlhjlkpnzkdgkjmemnzupmsvdrqqjttcplbois"
	};

	localparam int DrainCycles = 12;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	pce_byte_if byte_ch();
	pce_char_if letter_ch();

	pinyin_code_expander_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.syl       (byte_ch),
		.letter    (letter_ch)
	);

	letter_t    expected_letters[$];
	logic [7:0] spelled[$];
	logic [1:0] model_mode;
	logic       pair_open;
	logic [7:0] held_letter;
	bit         no_idle;
	int         mismatch_count;
	int         bytes_sent;
	int         letters_seen;
	int         syllables_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit one_of(input logic [7:0] c, input string set);
		for (int k = 0; k < set.len(); k++) begin
			if (set[k] == c) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void add_text(input string txt);
		for (int k = 0; k < txt.len(); k++) begin
			spelled.push_back(txt[k]);
		end
	endfunction

	function automatic void spell_syllable(input logic [7:0] s, input logic [7:0] y);
		spelled.delete();
		case (model_mode)
			MODE_FULL: begin
				if (s == "i") add_text("ch");
				else if (s == "u") add_text("sh");
				else if (s == "v") add_text("zh");
				else spelled.push_back(s);
				case (y)
					"a": if (s != "a") add_text("a");
					"b": add_text("ou");
					"c": add_text("iao");
					"d": if (one_of(s, "jlnqx")) add_text("iang"); else add_text("uang");
					"e": if (s != "e") add_text("e");
					"f": add_text("en");
					"g": if (s != "e") add_text("eng"); else add_text("ng");
					"h": if (s != "a") add_text("ang"); else add_text("ng");
					"j": add_text("an");
					"k": add_text("ao");
					"l": add_text("ai");
					"m": add_text("ian");
					"n": if (s != "a" && s != "e") add_text("in"); else add_text("n");
					"o": if (s != "o") begin
						if (one_of(s, "abfmpqw")) add_text("o"); else add_text("uo");
					end
					"p": add_text("un");
					"q": add_text("iu");
					"r": if (s == "e") add_text("r"); else add_text("uan");
					"s": if (one_of(s, "jqx")) add_text("iong"); else add_text("ong");
					"t": add_text("ue");
					"v": if (one_of(s, "ln")) add_text("v"); else add_text("ui");
					"w": if (one_of(s, "djlqx")) add_text("ia"); else add_text("ua");
					"x": add_text("ie");
					"y": if (one_of(s, "ighkuv")) add_text("uai"); else add_text("ing");
					"z": add_text("ei");
					default: spelled.push_back(y);
				endcase
			end
			MODE_INITIAL: begin
				if (s == "i") spelled.push_back("c");
				else if (s == "u") spelled.push_back("s");
				else if (s == "v") spelled.push_back("z");
				else spelled.push_back(s);
			end
			default: begin
				spelled.push_back(s);
				spelled.push_back(y);
			end
		endcase
		for (int k = 0; k < spelled.size(); k++) begin
			expected_letters.push_back('{ch: spelled[k], last: (k == spelled.size() - 1)});
		end
	endfunction

	function automatic void predict_letters(input logic [7:0] b);
		int pos;
		if (pair_open) begin
			pair_open = 1'b0;
			spell_syllable(held_letter, b);
		end else if (b >= RomHighBase || b <= RomLowTop) begin
			pos = (b >= RomHighBase) ? 2 * (int'(b) - int'(RomHighBase)) :
				2 * (int'(b) + int'(RomLowOffset));
			spell_syllable(SylCodes[pos], SylCodes[pos + 1]);
		end else begin
			held_letter = b;
			pair_open = 1'b1;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		predict_letters(b);
		bytes_sent++;
	endtask

	task automatic send_pair(input logic [7:0] first, input logic [7:0] second);
		send_byte(first);
		send_byte(second);
	endtask

	task automatic wait_all_letters();
		byte_ch.valid <= 1'b0;
		while (expected_letters.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		wait_all_letters();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_mode = m;
	endtask

	function automatic logic [7:0] rand_letter();
		return 8'("a") + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_code_byte();
		return $urandom_range(0, 1) ? 8'($urandom_range(8'h7b, 8'hff)) :
			8'($urandom_range(8'h00, 8'h3a));
	endfunction

	task automatic test_code_bytes();
		write_mode(MODE_CODE);
		send_byte(8'h00);
		send_byte(8'h3a);
		send_byte(8'h7b);
		send_byte(8'hff);
		send_pair(8'h3b, 8'h3a);
		send_pair(8'h7a, 8'hff);
	endtask

	task automatic test_full_spelling();
		write_mode(MODE_FULL);
		send_pair("a", "a");
		send_pair("v", "y");
		send_pair("j", "d");
		send_pair("x", "s");
		send_pair("b", "i");
		send_byte(8'h7b);
	endtask

	task automatic test_initial_only();
		write_mode(MODE_INITIAL);
		send_pair("u", "x");
		send_byte(8'h9f);
	endtask

	task automatic test_unused_mode();
		write_mode(2'd3);
		send_byte(8'h00);
	endtask

	task automatic test_mode_change_mid_pair();
		write_mode(MODE_CODE);
		send_byte("q");
		write_mode(MODE_FULL);
		send_byte("w");
	endtask

	task automatic test_random_stream(input logic [1:0] m, input int count);
		int pick;
		write_mode(m);
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if (k == count / 2) wait_all_letters();
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				send_byte(rand_code_byte());
			end else if (pick < 8) begin
				send_pair($urandom_range(0, 3) == 0 ? 8'($urandom_range(8'h3b, 8'h7a)) :
					rand_letter(), $urandom_range(0, 4) == 0 ? 8'($urandom) : rand_letter());
				k++;
			end else begin
				send_byte(8'($urandom));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int gap;
		letter_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				letter_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			letter_ch.ready <= 1'b1;
			do @(posedge clk); while (!letter_ch.valid);
			letters_seen++;
			if (letter_ch.syllable_end) syllables_seen++;
			if (expected_letters.size() == 0) begin
				$error("unexpected letter transfer: out_char %h syllable_end %b",
					letter_ch.out_char, letter_ch.syllable_end);
				mismatch_count++;
			end else begin
				letter_t exp_l;
				exp_l = expected_letters.pop_front();
				if (letter_ch.out_char !== exp_l.ch) begin
					$error("out_char: expected %h, actual %h", exp_l.ch, letter_ch.out_char);
					mismatch_count++;
				end
				if (letter_ch.syllable_end !== exp_l.last) begin
					$error("syllable_end: expected %b, actual %b", exp_l.last,
						letter_ch.syllable_end);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(10 * 2_000_000);
		$display("pinyin_code_expander_core test failed");
		$finish;
	end

	initial begin
		model_mode = MODE_CODE;
		pair_open = 1'b0;
		held_letter = '0;
		no_idle = 1'b0;
		mismatch_count = 0;
		bytes_sent = 0;
		letters_seen = 0;
		syllables_seen = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.in_byte <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_code_bytes();
		test_full_spelling();
		test_initial_only();
		test_unused_mode();
		test_mode_change_mid_pair();
		test_random_stream(MODE_FULL, 200);
		test_random_stream(MODE_CODE, 120);
		test_random_stream(MODE_INITIAL, 130);

		wait_all_letters();
		if (expected_letters.size() != 0) begin
			$error("%0d expected letters never arrived", expected_letters.size());
			mismatch_count++;
		end
		$display("Sent %0d bytes across code, full, initial and unused modes;", bytes_sent);
		$display("checked %0d letters in %0d syllables, %0d mismatches.",
			letters_seen, syllables_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("pinyin_code_expander_core test passed");
		end else begin
			$display("pinyin_code_expander_core test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/pce_pkg.sv
hdl/pce_byte_if.sv
hdl/pce_char_if.sv
hdl/pce_front.sv
hdl/pce_queue.sv
hdl/pce_back.sv
hdl/pinyin_code_expander_core.sv
bench/tb_top.sv
